// File: rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and codes for the cursor sequence buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

  // action codes
  localparam logic [3:0] ACT_START     = 4'd0;
  localparam logic [3:0] ACT_END       = 4'd1;
  localparam logic [3:0] ACT_LAST      = 4'd2;
  localparam logic [3:0] ACT_ADVANCE   = 4'd3;
  localparam logic [3:0] ACT_RETREAT   = 4'd4;
  localparam logic [3:0] ACT_INSERT    = 4'd5;
  localparam logic [3:0] ACT_ATTACH    = 4'd6;
  localparam logic [3:0] ACT_REMOVE    = 4'd7;
  localparam logic [3:0] ACT_FRONT_INS = 4'd8;
  localparam logic [3:0] ACT_BACK_ATT  = 4'd9;
  localparam logic [3:0] ACT_FRONT_REM = 4'd10;
  localparam logic [3:0] ACT_READ      = 4'd11;
  localparam logic [3:0] ACT_READ_AT   = 4'd12;

  // error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_NO_CUR = 2'd2;
  localparam logic [1:0] ERR_RANGE  = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] entry_value;
    logic [4:0]  read_index;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [5:0]  item_count;
    logic        has_current;
    logic [1:0]  error_code;
  } out_beat_t;

  // broadcast command to the row of entry cells
  typedef struct packed {
    logic ins;   // open a gap at pos and load the new word there
    logic rem;   // close the gap at pos
  } row_cmd_t;

endpackage

`default_nettype wire

// File: rtl/cursor_sequence_buffer.sv
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// Ordered store of up to DEPTH words with a cursor, built as a row of entry
// cells that shift up on insert and down on remove.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat type   | handshake
//   --------+-----+-------------+-------------------------
//   in_     | in  | in_beat_t   | in_valid / in_ready
//   out_    | out | out_beat_t  | out_valid / out_ready
//
// One beat per cycle while in_ready is high: every action, including a full-row
// shift, finishes in the cycle it is accepted, and its result is registered.
// The whole row shifts at once since each cell looks at its neighbors.
// An output register plus one skid register let input keep flowing for one
// beat while out_ready is low; in_ready drops once the skid is holding a beat.
// Reset clears cursor, count and handshake state; entry words are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_buffer
  import csb_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_POS = CW'(DEPTH - 1);

  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                 accept;
  logic                 cur_valid;
  logic                 full;
  logic [CW-1:0]        pos;
  row_cmd_t             cmd;
  logic                 do_read;
  logic [AW-1:0]        rd_addr;
  logic [1:0]           err;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] words [DEPTH];
  out_beat_t            result;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t skid_r, skid_nxt;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign cur_valid = (cur_r < cnt_r);
  assign full      = (cnt_r == FULL_CNT);
  assign new_word  = WORD_BITS'(in_data.entry_value);

  // action decode
  always_comb begin
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    pos     = '0;
    cmd     = '0;
    do_read = 1'b0;
    rd_addr = cur_r[AW-1:0];
    err     = ERR_OK;
    unique case (in_data.action) inside
      ACT_START: begin
        cur_nxt = '0;
      end
      ACT_END: begin
        if (cnt_r != '0) begin
          cur_nxt = cnt_r - 1'b1;
        end
      end
      ACT_LAST: begin
        cur_nxt = LAST_POS;
      end
      ACT_ADVANCE: begin
        if (cur_valid) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          err = ERR_NO_CUR;
        end
      end
      ACT_RETREAT: begin
        if (cur_r != '0) begin
          cur_nxt = cur_r - 1'b1;
        end
      end
      ACT_INSERT, ACT_ATTACH, ACT_FRONT_INS, ACT_BACK_ATT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          case (in_data.action)
            ACT_INSERT:    pos = cur_valid ? cur_r : '0;
            ACT_ATTACH:    pos = cur_valid ? cur_r + 1'b1 : cnt_r;
            ACT_FRONT_INS: pos = '0;
            default:       pos = cnt_r;
          endcase
          cmd.ins = 1'b1;
          cur_nxt = pos;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!cur_valid) begin
          err = ERR_NO_CUR;
        end else begin
          pos     = cur_r;
          cmd.rem = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ACT_FRONT_REM: begin
        if (cnt_r == '0) begin
          err = ERR_NO_CUR;
        end else begin
          pos     = '0;
          cmd.rem = 1'b1;
          cur_nxt = '0;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ACT_READ: begin
        if (cur_valid) begin
          do_read = 1'b1;
        end else begin
          err = ERR_NO_CUR;
        end
      end
      ACT_READ_AT: begin
        rd_addr = AW'(in_data.read_index);
        if (IW'(in_data.read_index) < IW'(cnt_r)) begin
          do_read = 1'b1;
        end else begin
          err = ERR_RANGE;
        end
      end
      default: begin
        // unused codes do nothing
      end
    endcase
  end

  // row of entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = words[g];
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = words[g];
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    csb_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (accept ? cmd : row_cmd_t'('0)),
      .pos        (pos),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (words[g])
    );
  end

  assign rd_word = do_read ? words[rd_addr] : '0;

  always_comb begin
    result.read_word   = 32'(rd_word);
    result.item_count  = 6'(cnt_nxt);
    result.has_current = (cur_nxt < cnt_nxt);
    result.error_code  = err;
  end

  // output register with one skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_ready || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || accept;
      out_nxt        = skid_valid_r ? skid_r : result;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cur_r <= cur_nxt;
        cnt_r <= cnt_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/csb_cell.sv
// ----------------------------------------------------------------------------
// csb_cell
// One entry of the sequence row: holds a word, loads the new word, or takes
// its neighbor's word when the row shifts up or down.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_cell
  import csb_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int CW        = 6,
  parameter int IDX       = 0
) (
  input  wire logic                 clk,
  input  wire row_cmd_t             cmd,
  input  wire logic [CW-1:0]        pos,
  input  wire logic [WORD_BITS-1:0] new_word,
  input  wire logic [WORD_BITS-1:0] left_word,
  input  wire logic [WORD_BITS-1:0] right_word,
  output logic      [WORD_BITS-1:0] word_q
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (MY_IDX == pos) begin
        word_nxt = new_word;
      end else if (MY_IDX > pos) begin
        word_nxt = left_word;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

`default_nettype wire

// File: rtl/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks on the cursor sequence buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_checker
  import csb_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  localparam bit SMALL = (DEPTH < 64);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL |-> out_data.item_count <= 6'(DEPTH))
    else $error("item count above depth");

  // a full error only when the store is full
  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code == ERR_FULL |-> out_data.item_count == 6'(DEPTH))
    else $error("full error with room left");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != ERR_OK |-> out_data.read_word == '0)
    else $error("nonzero read word on error");

  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL && out_data.has_current |-> out_data.item_count != '0)
    else $error("current item in empty store");

endmodule

bind cursor_sequence_buffer csb_checker #(.DEPTH(DEPTH)) u_csb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb_cursor_sequence_buffer.sv
// ----------------------------------------------------------------------------
// tb_cursor_sequence_buffer
// Self-checking bench for the cursor sequence buffer: a short table of
// directed actions from reset, then random action streams that fill and
// drain the store under varying sender gaps and receiver stalls. Every
// result beat is checked field by field against the table's expected beat or an
// in-bench model of the store, its cursor and its count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cursor_sequence_buffer;
  import csb_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int PHASE_ITEMS = 435;

  // codes with no action behind them
  localparam logic [3:0] ACT_SPARE_FIRST = 4'd13;
  localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;

  typedef struct packed {
    bit        typed;
    out_beat_t want;
  } beat_hint_t;

  typedef struct packed {
    in_beat_t  stim;
    bit        typed;
    out_beat_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  // model of the store
  logic [31:0] model_store [STORE_DEPTH];
  int          model_cursor;
  int          model_count;

  beat_hint_t  hint_q [$];
  out_beat_t   expected_q [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_request;
  int          hold_left;
  bit          growing;

  cursor_sequence_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit model_has_current();
    return model_count > 0 && model_cursor < model_count;
  endfunction

  function automatic void model_place(int pos, logic [31:0] word);
    int i;
    for (i = model_count; i > pos; i--) begin
      if (i < STORE_DEPTH) model_store[i] = model_store[i-1];
    end
    if (pos < STORE_DEPTH) model_store[pos] = word;
    model_cursor = pos;
    model_count++;
  endfunction

  function automatic void model_close_gap(int pos);
    int i;
    for (i = pos; i + 1 < model_count && i + 1 < STORE_DEPTH; i++) begin
      model_store[i] = model_store[i+1];
    end
    model_count--;
  endfunction

  // applies one action to the model and returns the result it gives
  function automatic out_beat_t apply_action(in_beat_t b);
    out_beat_t r;
    bit        full;
    r = '0;
    full = model_count >= STORE_DEPTH;
    r.error_code = ERR_OK;
    case (b.action)
      ACT_START: model_cursor = 0;
      ACT_END: if (model_count > 0) model_cursor = model_count - 1;
      ACT_LAST: model_cursor = STORE_DEPTH - 1;
      ACT_ADVANCE: begin
        if (model_has_current()) model_cursor++;
        else r.error_code = ERR_NO_CUR;
      end
      ACT_RETREAT: if (model_cursor != 0) model_cursor--;
      ACT_INSERT: begin
        if (full) r.error_code = ERR_FULL;
        else model_place(model_has_current() ? model_cursor : 0, b.entry_value);
      end
      ACT_ATTACH: begin
        if (full) r.error_code = ERR_FULL;
        else model_place(model_has_current() ? model_cursor + 1 : model_count,
                         b.entry_value);
      end
      ACT_REMOVE: begin
        if (!model_has_current()) r.error_code = ERR_NO_CUR;
        else model_close_gap(model_cursor);
      end
      ACT_FRONT_INS: begin
        if (full) r.error_code = ERR_FULL;
        else model_place(0, b.entry_value);
      end
      ACT_BACK_ATT: begin
        if (full) r.error_code = ERR_FULL;
        else model_place(model_count, b.entry_value);
      end
      ACT_FRONT_REM: begin
        if (model_count == 0) begin
          r.error_code = ERR_NO_CUR;
        end else begin
          model_cursor = 0;
          model_close_gap(0);
        end
      end
      ACT_READ: begin
        if (model_has_current()) r.read_word = model_store[model_cursor];
        else r.error_code = ERR_NO_CUR;
      end
      ACT_READ_AT: begin
        if (int'(b.read_index) < model_count) r.read_word = model_store[b.read_index];
        else r.error_code = ERR_RANGE;
      end
      default: ;
    endcase
    r.item_count  = 6'(model_count);
    r.has_current = model_has_current();
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic [3:0] act, logic [31:0] value,
                                         logic [4:0] idx, bit typed,
                                         logic [31:0] word, logic [5:0] cnt,
                                         logic cur, logic [1:0] err);
    plan_row_t row;
    row.stim.action      = act;
    row.stim.entry_value = value;
    row.stim.read_index  = idx;
    row.typed            = typed;
    row.want.read_word   = word;
    row.want.item_count  = cnt;
    row.want.has_current = cur;
    row.want.error_code  = err;
    return row;
  endfunction

  // random action, weighted toward growing or shrinking the store
  function automatic in_beat_t make_random_beat();
    in_beat_t b;
    int       pick;
    int       grow_w;
    int       shrink_w;
    if (model_count >= STORE_DEPTH && $urandom_range(9) == 0) growing = 1'b0;
    if (model_count == 0) growing = 1'b1;
    grow_w   = growing ? 45 : 12;
    shrink_w = growing ? 10 : 40;
    pick = $urandom_range(99);
    b.entry_value = $urandom();
    if ($urandom_range(1) == 0 || model_count == 0) b.read_index = 5'($urandom_range(31));
    else b.read_index = 5'($urandom_range(model_count - 1));
    if (pick < grow_w) begin
      case ($urandom_range(3))
        0: b.action = ACT_INSERT;
        1: b.action = ACT_ATTACH;
        2: b.action = ACT_FRONT_INS;
        default: b.action = ACT_BACK_ATT;
      endcase
    end else if (pick < grow_w + shrink_w) begin
      b.action = ($urandom_range(2) == 0) ? ACT_FRONT_REM : ACT_REMOVE;
    end else if (pick < 78) begin
      case ($urandom_range(5))
        0: b.action = ACT_START;
        1: b.action = ACT_END;
        2: b.action = ACT_LAST;
        3: b.action = ACT_ADVANCE;
        default: b.action = ACT_RETREAT;
      endcase
    end else if (pick < 97) begin
      b.action = ($urandom_range(1) == 0) ? ACT_READ : ACT_READ_AT;
    end else begin
      b.action = 4'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    beat_hint_t h;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    h.typed = typed;
    h.want  = want;
    hint_q.push_back(h);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0 || hint_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    beat_hint_t h;
    out_beat_t  want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_word !== want.read_word) begin
            $error("read_word: expected %h, got %h", want.read_word, out_data.read_word);
            mismatches++;
          end
          if (out_data.item_count !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count,
                   out_data.item_count);
            mismatches++;
          end
          if (out_data.has_current !== want.has_current) begin
            $error("has_current: expected %b, got %b", want.has_current,
                   out_data.has_current);
            mismatches++;
          end
          if (out_data.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   out_data.error_code);
            mismatches++;
          end
        end
      end
      // the model runs on every accepted beat, typed rows included
      if (in_valid && in_ready) begin
        h    = hint_q.pop_front();
        want = apply_action(in_data);
        expected_q.push_back(h.typed ? h.want : want);
      end
    end
  end

  initial begin
    plan_row_t plan [$];
    int        idle_by_phase [4];
    int        stall_by_phase [4];
    int        ph;
    int        n;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    growing        = 1'b1;
    model_cursor   = 0;
    model_count    = 0;
    idle_by_phase  = '{0, 56, 0, 24};
    stall_by_phase = '{0, 0, 56, 24};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // empty store: each action fails, is a no-op or (last) only moves the cursor
    plan.push_back(plan_row(ACT_READ,      32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_NO_CUR));
    plan.push_back(plan_row(ACT_READ_AT,   32'h0, 5'd31, 1, 32'h0, 6'd0, 1'b0, ERR_RANGE));
    plan.push_back(plan_row(ACT_ADVANCE,   32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_NO_CUR));
    plan.push_back(plan_row(ACT_REMOVE,    32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_NO_CUR));
    plan.push_back(plan_row(ACT_FRONT_REM, 32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_NO_CUR));
    plan.push_back(plan_row(ACT_RETREAT,   32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_END,       32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_LAST,      32'h0, 5'd0,  1, 32'h0, 6'd0, 1'b0, ERR_OK));
    // insert with no current item lands at the front
    plan.push_back(plan_row(ACT_INSERT, 32'hFFFF_FFFF, 5'd0, 1,
                            32'h0, 6'd1, 1'b1, ERR_OK));
    plan.push_back(plan_row(ACT_READ, 32'h0, 5'd0, 1, 32'hFFFF_FFFF, 6'd1, 1'b1, ERR_OK));
    plan.push_back(plan_row(ACT_ATTACH, 32'h0, 5'd0, 0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_READ_AT, 32'hFFFF_FFFF, 5'd0, 1,
                            32'hFFFF_FFFF, 6'd2, 1'b1, ERR_OK));
    plan.push_back(plan_row(ACT_READ_AT,   32'h0,         5'd1,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_FRONT_INS, 32'hA5A5_A5A5, 5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_BACK_ATT,  32'h5A5A_5A5A, 5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_LAST,      32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_INSERT,    32'h1234_5678, 5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_LAST,      32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    // attach with no current item lands at the back
    plan.push_back(plan_row(ACT_ATTACH,    32'h8000_0001, 5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_ADVANCE,   32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_REMOVE,    32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_START,     32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_REMOVE,    32'h0,         5'd0,  0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_FRONT_REM, 32'h0,         5'd31, 0, 32'h0, 6'd0, 1'b0, ERR_OK));
    plan.push_back(plan_row(ACT_SPARE_LAST, 32'hFFFF_FFFF, 5'd31, 0,
                            32'h0, 6'd0, 1'b0, ERR_OK));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].stim, plan[i].typed, plan[i].want);
    wait_all_results();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off so the block fills and backs up its input
        if (ph == 0 && n == 100) hold_request = 150;
        send_beat(make_random_beat(), 1'b0, '0);
      end
      wait_all_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/csb_pkg.sv
rtl/csb_cell.sv
rtl/cursor_sequence_buffer.sv
rtl/csb_checker.sv
sim/tb_cursor_sequence_buffer.sv
